// ===== rtl/core/hrck_pkg.sv =====
`default_nettype none

package hrck_pkg;

  // channel and field widths
  localparam int unsigned ChW   = 8;
  localparam int unsigned HueW  = 9;
  localparam int unsigned NumW  = 17;
  localparam int unsigned CfgIdxW = 2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_HUE_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HUE_HIGH = 2'd1;

  // register reset values
  localparam logic [HueW-1:0] HUE_LOW_RST  = 9'd0;
  localparam logic [HueW-1:0] HUE_HIGH_RST = 9'd360;

  // one pixel as it enters the datapath
  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic           last;
  } pix_t;

  // pixel with its hue numerator and spread, between the two stages
  typedef struct packed {
    logic [ChW-1:0]  red;
    logic [ChW-1:0]  green;
    logic [ChW-1:0]  blue;
    logic [ChW-1:0]  hi;
    logic [ChW-1:0]  spread;
    logic [NumW-1:0] num;
    logic            last;
  } hue_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/hrck_hue.sv =====
`default_nettype none

module hrck_hue
  import hrck_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire pix_t       pix_i,
  output logic            valid_o,
  output hue_stage_t      stage_o
);

  localparam logic signed [18:0] K60  = 19'sd60;
  localparam logic signed [18:0] K120 = 19'sd120;
  localparam logic signed [18:0] K240 = 19'sd240;
  localparam logic signed [18:0] K360 = 19'sd360;

  logic [ChW-1:0]    hi, lo, m_rg, n_rg;
  logic [ChW-1:0]    spread;
  logic signed [18:0] rx, gx, bx, dx, num_s;
  hue_stage_t        stage_d, stage_q;
  logic              valid_q;

  // max and min of the three channels
  always_comb begin
    m_rg = (pix_i.red < pix_i.green) ? pix_i.green : pix_i.red;
    hi   = (m_rg < pix_i.blue) ? pix_i.blue : m_rg;
    n_rg = (pix_i.red > pix_i.green) ? pix_i.green : pix_i.red;
    lo   = (n_rg > pix_i.blue) ? pix_i.blue : n_rg;
    spread = hi - lo;
  end

  // hue numerator, hue = num / spread degrees
  always_comb begin
    rx = $signed({11'd0, pix_i.red});
    gx = $signed({11'd0, pix_i.green});
    bx = $signed({11'd0, pix_i.blue});
    dx = $signed({11'd0, spread});
    if (hi == pix_i.red) begin
      num_s = K60 * (gx - bx);
      if (num_s < 0) begin
        num_s = num_s + K360 * dx;
      end
    end else if (hi == pix_i.green) begin
      num_s = K60 * (bx - rx) + K120 * dx;
    end else begin
      num_s = K60 * (rx - gx) + K240 * dx;
    end
  end

  always_comb begin
    stage_d.red    = pix_i.red;
    stage_d.green  = pix_i.green;
    stage_d.blue   = pix_i.blue;
    stage_d.hi     = hi;
    stage_d.spread = spread;
    stage_d.num    = num_s[NumW-1:0];
    stage_d.last   = pix_i.last;
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== rtl/core/hrck_keep.sv =====
`default_nettype none

module hrck_keep
  import hrck_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire hue_stage_t      stage_i,
  input  wire logic [HueW-1:0] hue_low_i,
  input  wire logic [HueW-1:0] hue_high_i,
  output logic                 valid_o,
  output logic [ChW-1:0]       red_o,
  output logic [ChW-1:0]       green_o,
  output logic [ChW-1:0]       blue_o,
  output logic                 kept_o,
  output logic                 last_o
);

  logic [NumW-1:0] bound_lo, bound_hi;
  logic            kept;
  logic            valid_q;
  logic [ChW-1:0]  red_q, green_q, blue_q;
  logic            kept_q, last_q;

  // bounds scaled by the spread, exact compare against the numerator
  always_comb begin
    bound_lo = NumW'({8'd0, hue_low_i} * {9'd0, stage_i.spread});
    bound_hi = NumW'({8'd0, hue_high_i} * {9'd0, stage_i.spread});
    if (stage_i.spread == '0) begin
      kept = (hue_low_i == '0);
    end else begin
      kept = (stage_i.num >= bound_lo) && (stage_i.num <= bound_hi);
    end
  end

  // result valid strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // result pixel: unchanged when kept, gray at the max channel otherwise
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      red_q   <= kept ? stage_i.red   : stage_i.hi;
      green_q <= kept ? stage_i.green : stage_i.hi;
      blue_q  <= kept ? stage_i.blue  : stage_i.hi;
      kept_q  <= kept;
      last_q  <= stage_i.last;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign kept_o  = kept_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/hue_range_color_keep.sv =====
`default_nettype none

// Hue range color keep: pixels whose HSV hue lies in [hue_low, hue_high]
// pass unchanged, all others turn gray at their maximum channel value.
// Input: a pixel (red_i, green_i, blue_i, last_pixel_i) is taken at each
// rising edge with start high and busy low. busy is always low, so one
// pixel may be started in every cycle.
// Output: out_valid_o is high for exactly one cycle per pixel with the
// result on out_red_o, out_green_o, out_blue_o, hue_kept_o and
// end_of_image_o. Results come in input order. A result is on the ports
// once the pixel has passed the input, hue stage and result registers.
// At full rate there is one result per cycle. The receiver cannot stall,
// so nothing ever holds the pipeline.
// Timing: input register, then max/min and hue numerator into the hue
// stage register, then bound products and compare into the result register;
// the two 9x8 bound multiplies set the critical stage.
// Configuration: cfg_index_i 0 writes hue_low, 1 writes hue_high; other
// indexes are ignored. cfg_ready_o is always high. Write only while idle.
// Reset: clears all valid flags and loads hue_low = 0, hue_high = 360.

module hue_range_color_keep
  import hrck_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ChW-1:0]     red_i,
  input  wire logic [ChW-1:0]     green_i,
  input  wire logic [ChW-1:0]     blue_i,
  input  wire logic               last_pixel_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [HueW-1:0]    cfg_data_i,
  output logic                    out_valid_o,
  output logic [ChW-1:0]          out_red_o,
  output logic [ChW-1:0]          out_green_o,
  output logic [ChW-1:0]          out_blue_o,
  output logic                    hue_kept_o,
  output logic                    end_of_image_o
);

  logic [HueW-1:0] hue_low_q, hue_high_q;
  logic            in_valid_q;
  pix_t            pix_q;
  logic            hue_valid;
  hue_stage_t      hue_stage;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= HUE_LOW_RST;
      hue_high_q <= HUE_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HUE_LOW:  hue_low_q  <= cfg_data_i;
        CFG_HUE_HIGH: hue_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      pix_q.red   <= red_i;
      pix_q.green <= green_i;
      pix_q.blue  <= blue_i;
      pix_q.last  <= last_pixel_i;
    end
  end

  hrck_hue u_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .pix_i   (pix_q),
    .valid_o (hue_valid),
    .stage_o (hue_stage)
  );

  hrck_keep u_keep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (hue_valid),
    .stage_i    (hue_stage),
    .hue_low_i  (hue_low_q),
    .hue_high_i (hue_high_q),
    .valid_o    (out_valid_o),
    .red_o      (out_red_o),
    .green_o    (out_green_o),
    .blue_o     (out_blue_o),
    .kept_o     (hue_kept_o),
    .last_o     (end_of_image_o)
  );

`ifndef SYNTH
  // every result traces back to a pixel started ahead of the pipeline registers
  a_out_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(start && !busy, 3))
    else $error("result without a started pixel");

  // a rejected pixel comes out gray
  a_gray_when_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hue_kept_o |->
      (out_red_o == out_green_o) && (out_green_o == out_blue_o))
    else $error("desaturated pixel is not gray");

  // a kept pixel is the input pixel unchanged
  a_kept_unchanged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hue_kept_o |->
      (out_red_o == $past(red_i, 3)) && (out_green_o == $past(green_i, 3)) &&
      (out_blue_o == $past(blue_i, 3)))
    else $error("kept pixel altered");

  // end of image marker follows its pixel
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> end_of_image_o == $past(last_pixel_i, 3))
    else $error("end of image marker misaligned");
`endif

endmodule

`default_nettype wire
